>>> rtl/core/mipmap_texture_filter_assert.svh
// Assertion macros for the mipmap texture filter checker.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef MIPMAP_TEXTURE_FILTER_ASSERT_SVH
`define MIPMAP_TEXTURE_FILTER_ASSERT_SVH

// same-cycle implication
`define MTF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mipmap texture filter check failed");

// next-cycle implication
`define MTF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mipmap texture filter check failed");

`endif

>>> rtl/core/mtf_pkg.sv
// Shared constants, types and helper functions of the mipmap texture filter.
// No dependencies.
package mtf_pkg;

	localparam int MAX_SIZE_LOG2_DEF = 7;
	localparam int FRACTION_BITS_DEF = 8;

	localparam int COORD_W    = 17;
	localparam int DERIV_W    = 21;
	localparam int TEXEL_W    = 32;
	localparam int CH_W       = 8;
	localparam int SIZE_W     = 3;
	localparam int MODE_W     = 2;
	localparam int WLEVEL_W   = 3;
	localparam int RC_W       = 7;
	localparam int REG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;

	localparam logic [COORD_W-1:0] COORD_ONE  = 17'h10000;
	localparam logic [COORD_W-1:0] COORD_HALF = 17'h08000;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd7;
	localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;

	localparam logic [MODE_W-1:0] MODE_NEAREST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BILINEAR = 2'd1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SIZE_LOG2   = 1'b0,
		REG_FILTER_MODE = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_NEAREST   = 2'd0,
		KIND_BILINEAR  = 2'd1,
		KIND_TRILINEAR = 2'd2
	} kind_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size_log2;
		logic [MODE_W-1:0] filter_mode;
	} cfg_t;

	// entries in a pyramid of levels 0..m
	function automatic int unsigned store_depth(input int m);
		int unsigned d;
		d = 0;
		for (int j = 0; j <= 12; j++) begin
			if (j <= m)
				d += 32'd1 << (2 * j);
		end
		return d;
	endfunction

	// first entry of level lvl
	function automatic int unsigned level_base(input int m, input int lvl);
		int unsigned b;
		b = 0;
		for (int j = 0; j <= 12; j++) begin
			if (j < lvl && j <= m)
				b += 32'd1 << (2 * (m - j));
		end
		return b;
	endfunction

endpackage

>>> rtl/core/mtf_if.sv
// Request channels of the mipmap texture filter: item, result, configuration.
// Depends on mtf_pkg.
interface mtf_item_if;
	import mtf_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [WLEVEL_W-1:0]        write_level;
	logic [RC_W-1:0]            write_row;
	logic [RC_W-1:0]            write_column;
	logic [TEXEL_W-1:0]         write_texel;
	logic [COORD_W-1:0]         tex_u;
	logic [COORD_W-1:0]         tex_v;
	logic signed [DERIV_W-1:0]  du_dx;
	logic signed [DERIV_W-1:0]  dv_dx;

	modport source (output valid, command, write_level, write_row, write_column,
		write_texel, tex_u, tex_v, du_dx, dv_dx, input ready);
	modport sink (input valid, command, write_level, write_row, write_column,
		write_texel, tex_u, tex_v, du_dx, dv_dx, output ready);
endinterface

interface mtf_result_if;
	import mtf_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;
	logic [CH_W-1:0] alpha;

	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface mtf_cfg_if;
	import mtf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [REG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/mtf_front.sv
// Front end: accepts requests, works out level, weights and texel coordinates.
// Depends on mtf_pkg and mtf_if.
module mtf_front #(
	parameter int MAX_SIZE_LOG2 = mtf_pkg::MAX_SIZE_LOG2_DEF,
	parameter int FRACTION_BITS = mtf_pkg::FRACTION_BITS_DEF,
	parameter int EW            = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mtf_pkg::cfg_t cfg,
	mtf_item_if.sink      item,
	output logic          q_valid,
	input  logic          q_ready,
	output logic [EW-1:0] q_data
);
	import mtf_pkg::*;

	localparam int M  = MAX_SIZE_LOG2;
	localparam int F  = FRACTION_BITS;
	localparam int LW = $clog2(M + 1);
	localparam int SW = DERIV_W + M;
	localparam int MW = $clog2(SW);
	localparam int AW = $clog2(store_depth(M));
	localparam int PW = COORD_W + M;

	typedef enum logic [2:0] {
		FS_IDLE  = 3'b001,
		FS_LEVEL = 3'b010,
		FS_COORD = 3'b100
	} fstate_t;

	fstate_t state_q;

	logic                    is_write_q;
	logic [WLEVEL_W-1:0]     wlevel_q;
	logic [RC_W-1:0]         wrow_q, wcol_q;
	logic [TEXEL_W-1:0]      wdata_q;
	logic [COORD_W-1:0]      u_q, v_q;
	logic [SIZE_W-1:0]       s_q;
	logic [MODE_W-1:0]       mode_q;
	logic signed [SW-1:0]    scale_q;
	logic [LW-1:0]           k_q, k2_q;
	logic [F-1:0]            frac_q;
	kind_t                   kind_q;

	logic                    accept;
	logic [SIZE_W-1:0]       s_d;
	logic [COORD_W-1:0]      u_d, v_d;
	logic signed [SW-1:0]    du_ext, dv_ext, a_d, b_d;

	logic [MW-1:0]           m;
	logic [F-1:0]            frac_d;
	logic [LW-1:0]           k_d, k2_d;
	kind_t                   kind_d;
	int                      km, k2m;

	logic [LW-1:0]           lv [2];
	logic [PW-1:0]           pu [2], pv [2];
	logic [M-1:0]            iua [2], iub [2], iva [2], ivb [2];
	logic [F-1:0]            wu [2], wv [2];
	logic [AW-1:0]           base [2];
	logic [M-1:0]            lastv;
	logic [PW-1:0]           tu, tv;
	logic [M:0]              ncol, nrow, nlast;
	int                      lsz;

	logic                    wok;
	logic [AW-1:0]           waddr;
	int                      wsh;

	assign item.ready = (state_q == FS_IDLE);
	assign accept     = item.valid && item.ready;

	always_comb begin
		s_d = (int'(cfg.size_log2) > M) ? SIZE_W'(M) : cfg.size_log2;
		u_d = (item.tex_u > COORD_ONE) ? COORD_ONE : item.tex_u;
		v_d = (item.tex_v > COORD_ONE) ? COORD_ONE : item.tex_v;
		du_ext = {{M{item.du_dx[DERIV_W-1]}}, item.du_dx};
		dv_ext = {{M{item.dv_dx[DERIV_W-1]}}, item.dv_dx};
		a_d = du_ext <<< s_d;
		b_d = dv_ext <<< s_d;
	end

	always_comb begin
		km  = 0;
		k2m = 0;
		m   = '0;
		for (int i = 0; i < SW; i++) begin
			if (scale_q[i])
				m = MW'(i);
		end
		frac_d = F'($unsigned(scale_q) >> (int'(m) - F));
		km = int'(m) - 16;
		if (km > int'(s_q))
			km = int'(s_q);
		k2m = km + 1;
		if (k2m > int'(s_q))
			k2m = int'(s_q);
		k_d  = LW'(km);
		k2_d = LW'(k2m);
		if (mode_q == MODE_NEAREST)
			kind_d = KIND_NEAREST;
		else if (mode_q == MODE_BILINEAR)
			kind_d = KIND_BILINEAR;
		else if (scale_q > $signed(SW'(COORD_ONE)))
			kind_d = KIND_TRILINEAR;
		else
			kind_d = KIND_NEAREST;
		if (kind_d != KIND_TRILINEAR) begin
			k_d  = '0;
			k2_d = '0;
		end
	end

	always_comb begin
		lsz   = 0;
		lastv = '0;
		lv[0] = k_q;
		lv[1] = k2_q;
		for (int l = 0; l < 2; l++) begin
			lsz = int'(s_q) - int'(lv[l]);
			pu[l] = ({{M{1'b0}}, u_q} << lsz) - {{M{1'b0}}, u_q};
			pv[l] = ({{M{1'b0}}, v_q} << lsz) - {{M{1'b0}}, v_q};
			lastv = M'((1 << lsz) - 1);
			iua[l] = pu[l][16 +: M];
			iva[l] = pv[l][16 +: M];
			iub[l] = (iua[l] < lastv) ? iua[l] + 1'b1 : iua[l];
			ivb[l] = (iva[l] < lastv) ? iva[l] + 1'b1 : iva[l];
			wu[l] = pu[l][15 -: F];
			wv[l] = pv[l][15 -: F];
			base[l] = AW'(level_base(M, int'(lv[l])));
		end
		tu    = ({{M{1'b0}}, u_q} << s_q) + PW'(COORD_HALF);
		tv    = ({{M{1'b0}}, v_q} << s_q) + PW'(COORD_HALF);
		ncol  = tu[16 +: M + 1];
		nrow  = tv[16 +: M + 1];
		nlast = (M + 1)'((1 << int'(s_q)) - 1);
		if (kind_q == KIND_NEAREST) begin
			iua[0] = (ncol > nlast) ? nlast[M-1:0] : ncol[M-1:0];
			iva[0] = (nrow > nlast) ? nlast[M-1:0] : nrow[M-1:0];
		end
	end

	always_comb begin
		wsh = M - int'(wlevel_q);
		wok = (int'(wlevel_q) <= M) && (int'(wrow_q) < (1 << wsh))
			&& (int'(wcol_q) < (1 << wsh));
		waddr = AW'(level_base(M, int'(wlevel_q)) + (int'(wrow_q) << wsh) + int'(wcol_q));
	end

	assign q_valid = (state_q == FS_COORD) && (!is_write_q || wok);
	assign q_data  = {is_write_q, kind_q, wdata_q, waddr,
		base[0], lv[0], iua[0], iub[0], iva[0], ivb[0], wu[0], wv[0],
		base[1], lv[1], iua[1], iub[1], iva[1], ivb[1], wu[1], wv[1], frac_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			unique case (state_q)
				FS_IDLE: begin
					if (accept)
						state_q <= FS_LEVEL;
				end
				FS_LEVEL: begin
					state_q <= FS_COORD;
				end
				FS_COORD: begin
					if (!q_valid || q_ready)
						state_q <= FS_IDLE;
				end
				default: begin
					state_q <= FS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_write_q <= !item.command;
			wlevel_q   <= item.write_level;
			wrow_q     <= item.write_row;
			wcol_q     <= item.write_column;
			wdata_q    <= item.write_texel;
			u_q        <= u_d;
			v_q        <= v_d;
			s_q        <= s_d;
			mode_q     <= cfg.filter_mode;
			scale_q    <= (a_d > b_d) ? a_d : b_d;
		end
		if (state_q == FS_LEVEL) begin
			k_q    <= k_d;
			k2_q   <= k2_d;
			frac_q <= frac_d;
			kind_q <= kind_d;
		end
	end

endmodule

>>> rtl/core/mtf_queue.sv
// Two-entry queue between the front and back ends.
// No dependencies.
module mtf_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic [W-1:0] data_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   count_q;
	logic         push, pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = data_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			data_q[wr_ptr_q] <= in_data;
	end

endmodule

>>> rtl/core/mtf_back.sv
// Back end: texel store, fetch sequencer, blend unit and output register.
// Depends on mtf_pkg and mtf_if.
module mtf_back #(
	parameter int MAX_SIZE_LOG2 = mtf_pkg::MAX_SIZE_LOG2_DEF,
	parameter int FRACTION_BITS = mtf_pkg::FRACTION_BITS_DEF,
	parameter int EW            = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  logic [EW-1:0] q_data,
	mtf_result_if.source  result
);
	import mtf_pkg::*;

	localparam int M     = MAX_SIZE_LOG2;
	localparam int F     = FRACTION_BITS;
	localparam int LW    = $clog2(M + 1);
	localparam int DEPTH = store_depth(M);
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [4:0] {
		B_IDLE  = 5'b00001,
		B_READ  = 5'b00010,
		B_DRAIN = 5'b00100,
		B_BLEND = 5'b01000,
		B_OUT   = 5'b10000
	} bstate_t;

	bstate_t state_q;

	logic               e_write;
	logic [1:0]         e_kind;
	logic [TEXEL_W-1:0] e_wdata;
	logic [AW-1:0]      e_waddr;
	logic [AW-1:0]      e_base [2];
	logic [LW-1:0]      e_lv [2];
	logic [M-1:0]       e_iua [2], e_iub [2], e_iva [2], e_ivb [2];
	logic [F-1:0]       e_wu [2], e_wv [2];
	logic [F-1:0]       e_frac;

	assign {e_write, e_kind, e_wdata, e_waddr,
		e_base[0], e_lv[0], e_iua[0], e_iub[0], e_iva[0], e_ivb[0], e_wu[0], e_wv[0],
		e_base[1], e_lv[1], e_iua[1], e_iub[1], e_iva[1], e_ivb[1], e_wu[1], e_wv[1],
		e_frac} = q_data;

	kind_t              kind_q;
	logic [AW-1:0]      base_q [2];
	logic [LW-1:0]      lv_q [2];
	logic [M-1:0]       iua_q [2], iub_q [2], iva_q [2], ivb_q [2];
	logic [F-1:0]       wu_q [2], wv_q [2];
	logic [F-1:0]       frac_q;
	logic [2:0]         r_q, step_q;
	logic [2:0]         last_rd, last_step;
	logic               rd_v_s1;
	logic [2:0]         rd_idx_s1;
	logic [TEXEL_W-1:0] rdata_s1;
	logic [TEXEL_W-1:0] n_q [8];
	logic               out_v_q;
	logic [TEXEL_W-1:0] out_q;

	logic [TEXEL_W-1:0] mem [DEPTH];
	logic               pop, mem_we, mem_re, out_load;
	logic [AW-1:0]      mem_addr, raddr;
	logic [M-1:0]       rrow, rcol;
	logic [2*M-1:0]     rsh;

	logic [2:0]         b_dst, b_a, b_b;
	logic [F-1:0]       b_w;
	logic [TEXEL_W-1:0] b_res;

	function automatic logic [TEXEL_W-1:0] blend(input logic [TEXEL_W-1:0] a,
		input logic [TEXEL_W-1:0] b, input logic [F-1:0] w);
		logic [F:0]         wa, wb;
		logic [F+9:0]       acc;
		logic [TEXEL_W-1:0] r;
		wb = {1'b0, w};
		wa = ((F + 1)'(1) << F) - wb;
		r  = '0;
		for (int ch = 0; ch < 4; ch++) begin
			acc = (F + 10)'(a[ch*CH_W +: CH_W]) * (F + 10)'(wa)
				+ (F + 10)'(b[ch*CH_W +: CH_W]) * (F + 10)'(wb)
				+ ((F + 10)'(1) << (F - 1));
			r[ch*CH_W +: CH_W] = acc[F +: CH_W];
		end
		return r;
	endfunction

	assign q_ready = (state_q == B_IDLE);
	assign pop     = q_valid && q_ready;
	assign mem_we  = pop && e_write;
	assign mem_re  = (state_q == B_READ);

	always_comb begin
		rrow  = r_q[0] ? ivb_q[r_q[2]] : iva_q[r_q[2]];
		rcol  = r_q[1] ? iub_q[r_q[2]] : iua_q[r_q[2]];
		rsh   = {{M{1'b0}}, rrow} << (M - int'(lv_q[r_q[2]]));
		raddr = base_q[r_q[2]] + AW'(rsh) + AW'(rcol);
		mem_addr = (state_q == B_IDLE) ? e_waddr : raddr;
	end

	always_comb begin
		case (kind_q)
			KIND_NEAREST: begin
				last_rd   = 3'd0;
				last_step = 3'd0;
			end
			KIND_BILINEAR: begin
				last_rd   = 3'd3;
				last_step = 3'd2;
			end
			default: begin
				last_rd   = 3'd7;
				last_step = 3'd6;
			end
		endcase
	end

	// columns first, then rows, then across levels
	always_comb begin
		case (step_q)
			3'd0: begin b_dst = 3'd0; b_a = 3'd0; b_b = 3'd2; b_w = wu_q[0]; end
			3'd1: begin b_dst = 3'd1; b_a = 3'd1; b_b = 3'd3; b_w = wu_q[0]; end
			3'd2: begin b_dst = 3'd0; b_a = 3'd0; b_b = 3'd1; b_w = wv_q[0]; end
			3'd3: begin b_dst = 3'd4; b_a = 3'd4; b_b = 3'd6; b_w = wu_q[1]; end
			3'd4: begin b_dst = 3'd5; b_a = 3'd5; b_b = 3'd7; b_w = wu_q[1]; end
			3'd5: begin b_dst = 3'd4; b_a = 3'd4; b_b = 3'd5; b_w = wv_q[1]; end
			default: begin b_dst = 3'd0; b_a = 3'd0; b_b = 3'd4; b_w = frac_q; end
		endcase
		b_res = blend(n_q[b_a], n_q[b_b], b_w);
	end

	assign out_load = (state_q == B_OUT) && (!out_v_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			r_q       <= 3'd0;
			step_q    <= 3'd0;
			rd_v_s1   <= 1'b0;
			rd_idx_s1 <= 3'd0;
			out_v_q   <= 1'b0;
		end else begin
			rd_v_s1   <= mem_re;
			rd_idx_s1 <= r_q;
			if (out_load)
				out_v_q <= 1'b1;
			else if (result.ready)
				out_v_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					r_q    <= 3'd0;
					step_q <= 3'd0;
					if (pop && !e_write)
						state_q <= B_READ;
				end
				B_READ: begin
					if (r_q == last_rd)
						state_q <= B_DRAIN;
					else
						r_q <= r_q + 3'd1;
				end
				B_DRAIN: begin
					state_q <= (kind_q == KIND_NEAREST) ? B_OUT : B_BLEND;
				end
				B_BLEND: begin
					if (step_q == last_step)
						state_q <= B_OUT;
					else
						step_q <= step_q + 3'd1;
				end
				B_OUT: begin
					if (out_load)
						state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= e_wdata;
		if (mem_re)
			rdata_s1 <= mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (pop && !e_write) begin
			kind_q <= kind_t'(e_kind);
			frac_q <= e_frac;
			for (int l = 0; l < 2; l++) begin
				base_q[l] <= e_base[l];
				lv_q[l]   <= e_lv[l];
				iua_q[l]  <= e_iua[l];
				iub_q[l]  <= e_iub[l];
				iva_q[l]  <= e_iva[l];
				ivb_q[l]  <= e_ivb[l];
				wu_q[l]   <= e_wu[l];
				wv_q[l]   <= e_wv[l];
			end
		end
		if (rd_v_s1)
			n_q[rd_idx_s1] <= rdata_s1;
		else if (state_q == B_BLEND)
			n_q[b_dst] <= b_res;
		if (out_load)
			out_q <= n_q[0];
	end

	assign result.valid = out_v_q;
	assign result.red   = out_q[31:24];
	assign result.green = out_q[23:16];
	assign result.blue  = out_q[15:8];
	assign result.alpha = out_q[7:0];

endmodule

>>> rtl/core/mipmap_texture_filter.sv
// Top level of the mipmap texture filter: configuration registers and the
// front end, queue and back end. Depends on mtf_pkg, mtf_if and the mtf_* modules.
//
// Write requests load one RGBA8 texel into the mip store; sample requests return one
// filtered texel (nearest, bilinear or trilinear). The front end takes a new request only
// after the last one has passed its IDLE, LEVEL and COORD states. In the back end a
// sample takes one single-port store read per texel (1, 4 or 8), a drain state, one
// shared blend unit step per blend (0, 3 or 7) and the output hand-off. The store is
// not cleared by reset; sample only texels written.
module mipmap_texture_filter #(
	parameter int MAX_SIZE_LOG2 = mtf_pkg::MAX_SIZE_LOG2_DEF,
	parameter int FRACTION_BITS = mtf_pkg::FRACTION_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mtf_item_if.sink     item,
	mtf_result_if.source result,
	mtf_cfg_if.sink      cfg
);
	import mtf_pkg::*;

	localparam int M  = MAX_SIZE_LOG2;
	localparam int F  = FRACTION_BITS;
	localparam int LW = $clog2(M + 1);
	localparam int AW = $clog2(store_depth(M));
	localparam int EW = 3 + TEXEL_W + 3 * AW + 2 * LW + 8 * M + 5 * F;

	cfg_t          cfg_q;
	logic          fq_valid, fq_ready, qb_valid, qb_ready;
	logic [EW-1:0] fq_data, qb_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size_log2   <= SIZE_RESET;
			cfg_q.filter_mode <= MODE_RESET;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_SIZE_LOG2:   cfg_q.size_log2   <= cfg.data[SIZE_W-1:0];
				REG_FILTER_MODE: cfg_q.filter_mode <= cfg.data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	mtf_front #(.MAX_SIZE_LOG2(M), .FRACTION_BITS(F), .EW(EW)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.item    (item),
		.q_valid (fq_valid),
		.q_ready (fq_ready),
		.q_data  (fq_data)
	);

	mtf_queue #(.W(EW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_data),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_data  (qb_data)
	);

	mtf_back #(.MAX_SIZE_LOG2(M), .FRACTION_BITS(F), .EW(EW)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (qb_valid),
		.q_ready (qb_ready),
		.q_data  (qb_data),
		.result  (result)
	);

endmodule

>>> rtl/core/mtf_checker.sv
// Port-level checks of the mipmap texture filter, bound to the top level.
// Depends on mipmap_texture_filter_assert.svh.
`include "mipmap_texture_filter_assert.svh"

module mtf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] result_red,
	input logic [7:0] result_alpha,
	input logic       cfg_ready
);

	`MTF_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid)
	`MTF_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result_red) && $stable(result_alpha))
	`MTF_ASSERT_NEXT(a_item_gap, item_valid && item_ready, !item_ready)
	`MTF_ASSERT_NOW(a_cfg_open, 1'b1, cfg_ready)

endmodule

bind mipmap_texture_filter mtf_checker u_mtf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_red   (result.red),
	.result_alpha (result.alpha),
	.cfg_ready    (cfg.ready)
);

>>> tb/tb_mipmap_texture_filter.sv
// Self-checking testbench of mipmap_texture_filter: directed table then random phases.
// Depends on mtf_pkg, mtf_if and the RTL of the filter.
`timescale 1ns / 100ps

module tb_mipmap_texture_filter;
	import mtf_pkg::*;

	localparam int TOP_LVL    = 7;
	localparam int FILL_LOG2  = 4;
	localparam int MEM_DEPTH  = 21845;
	localparam int IDLE_GAP   = 40;
	localparam int STALL_MAX  = 1000;
	localparam int PHASE_REQS = 200;

	typedef struct {
		logic                      command;
		logic [WLEVEL_W-1:0]       level;
		logic [RC_W-1:0]           row;
		logic [RC_W-1:0]           col;
		logic [TEXEL_W-1:0]        texel;
		logic [COORD_W-1:0]        u;
		logic [COORD_W-1:0]        v;
		logic signed [DERIV_W-1:0] du;
		logic signed [DERIV_W-1:0] dv;
	} tex_req_t;

	typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

	typedef struct {
		row_kind_t             kind;
		tex_req_t              req;
		reg_idx_t              idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  fixed;
		logic [TEXEL_W-1:0]    texel_due;
	} stim_row_t;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	logic clk;
	logic arst_n;

	mtf_item_if   item();
	mtf_result_if result();
	mtf_cfg_if    cfg();

	mipmap_texture_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.result(result),
		.cfg(cfg)
	);

	logic [TEXEL_W-1:0] texel_mem [0:MEM_DEPTH-1];
	logic [TEXEL_W-1:0] texels_due[$];
	logic [SIZE_W-1:0]  cur_size;
	logic [MODE_W-1:0]  cur_mode;
	int errors;
	int n_samples;
	int n_writes;
	int n_checked;
	int quiet_cycles;
	bit calm;
	int stall_left;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned lvl_start(input int lvl);
		int unsigned b;
		b = 0;
		for (int j = 0; j < lvl; j++)
			b += 1 << (2 * (TOP_LVL - j));
		return b;
	endfunction

	function automatic logic [31:0] fetch_texel(input int lvl, input int lsz,
			input longint unsigned row, input longint unsigned col);
		longint unsigned last;
		longint unsigned idx;
		last = (64'd1 << lsz) - 1;
		if (row > last) row = last;
		if (col > last) col = last;
		idx = lvl_start(lvl) + (row << (TOP_LVL - lvl)) + col;
		if (idx >= MEM_DEPTH) return 32'd0;
		return texel_mem[idx];
	endfunction

	function automatic logic [31:0] mix_texel(input logic [31:0] a, input logic [31:0] b,
			input longint unsigned w);
		logic [31:0] r;
		longint unsigned c;
		r = 0;
		for (int sh = 24; sh >= 0; sh -= 8) begin
			c = ((a >> sh) & 8'hFF) * (256 - w) + ((b >> sh) & 8'hFF) * w + 128;
			r |= ((c >> 8) & 8'hFF) << sh;
		end
		return r;
	endfunction

	function automatic logic [31:0] nearest_texel(input int s, input longint unsigned u,
			input longint unsigned v);
		return fetch_texel(0, s, ((v << s) + 32768) >> 16, ((u << s) + 32768) >> 16);
	endfunction

	function automatic logic [31:0] bilinear_texel(input int s, input int lvl,
			input longint unsigned u, input longint unsigned v);
		int lsz;
		longint unsigned span, pu, pv, iu, iv, wu, wv;
		logic [31:0] top, bot;
		lsz = s - lvl;
		span = (64'd1 << lsz) - 1;
		pu = span * u;
		pv = span * v;
		iu = pu >> 16;
		iv = pv >> 16;
		wu = (pu & 16'hFFFF) >> 8;
		wv = (pv & 16'hFFFF) >> 8;
		top = mix_texel(fetch_texel(lvl, lsz, iv, iu), fetch_texel(lvl, lsz, iv, iu + 1), wu);
		bot = mix_texel(fetch_texel(lvl, lsz, iv + 1, iu),
			fetch_texel(lvl, lsz, iv + 1, iu + 1), wu);
		return mix_texel(top, bot, wv);
	endfunction

	function automatic logic [31:0] trilinear_texel(input int s, input longint unsigned u,
			input longint unsigned v, input longint du, input longint dv);
		longint a, b, sc;
		longint unsigned scale, frac;
		int m, k, k2;
		a = du * (64'sd1 <<< s);
		b = dv * (64'sd1 <<< s);
		sc = a > b ? a : b;
		if (sc <= 65536) return nearest_texel(s, u, v);
		scale = sc;
		m = 0;
		while (m < 63 && (scale >> (m + 1)) != 0) m++;
		frac = (scale - (64'd1 << m)) >> (m - 8);
		k = m - 16;
		if (k > s) k = s;
		k2 = k + 1;
		if (k2 > s) k2 = s;
		return mix_texel(bilinear_texel(s, k, u, v), bilinear_texel(s, k2, u, v), frac);
	endfunction

	// applies one accepted write to the shadow store, or gives the filtered texel of a sample; returns 1 for a sample
	function automatic bit apply_req(input tex_req_t r, output logic [31:0] texel);
		int s;
		longint unsigned u, v, lim;
		texel = 0;
		if (r.command == CMD_WRITE) begin
			lim = 64'd1 << (TOP_LVL - r.level);
			if (r.row < lim && r.col < lim)
				texel_mem[lvl_start(r.level) + r.row * lim + r.col] = r.texel;
			return 1'b0;
		end
		s = cur_size > TOP_LVL ? TOP_LVL : cur_size;
		u = r.u > COORD_ONE ? COORD_ONE : r.u;
		v = r.v > COORD_ONE ? COORD_ONE : r.v;
		if (cur_mode == MODE_NEAREST)
			texel = nearest_texel(s, u, v);
		else if (cur_mode == MODE_BILINEAR)
			texel = bilinear_texel(s, 0, u, v);
		else
			texel = trilinear_texel(s, u, v, longint'(r.du), longint'(r.dv));
		return 1'b1;
	endfunction

	task automatic send_req(input tex_req_t r, input bit fixed, input logic [31:0] fixed_texel);
		logic [31:0] texel;
		if (!calm && $urandom_range(0, 3) == 0) begin
			item.valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		item.command      = r.command;
		item.write_level  = r.level;
		item.write_row    = r.row;
		item.write_column = r.col;
		item.write_texel  = r.texel;
		item.tex_u        = r.u;
		item.tex_v        = r.v;
		item.du_dx        = r.du;
		item.dv_dx        = r.dv;
		item.valid        = 1'b1;
		do @(posedge clk); while (!item.ready);
		if (apply_req(r, texel)) begin
			texels_due.push_back(fixed ? fixed_texel : texel);
			n_samples++;
		end else begin
			n_writes++;
		end
		@(negedge clk);
		item.valid = 1'b0;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		while (texels_due.size() != 0) @(negedge clk);
		repeat (IDLE_GAP) @(negedge clk);
		cfg.index = idx;
		cfg.data  = data;
		cfg.valid = 1'b1;
		do @(posedge clk); while (!cfg.ready);
		if (idx == REG_SIZE_LOG2) cur_size = data[SIZE_W-1:0];
		else cur_mode = data[MODE_W-1:0];
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	function automatic tex_req_t wr_req(input int lvl, input int row, input int col,
			input logic [31:0] texel);
		tex_req_t r;
		r = '{default: '0};
		r.command = CMD_WRITE;
		r.level   = lvl;
		r.row     = row;
		r.col     = col;
		r.texel   = texel;
		return r;
	endfunction

	function automatic tex_req_t rd_req(input int u, input int v, input int du, input int dv);
		tex_req_t r;
		r = '{default: '0};
		r.command = CMD_SAMPLE;
		r.u       = u;
		r.v       = v;
		r.du      = du;
		r.dv      = dv;
		return r;
	endfunction

	function automatic stim_row_t req_row(input tex_req_t r, input bit fixed,
			input logic [31:0] texel);
		stim_row_t t;
		t = '{kind: ROW_REQ, req: r, idx: REG_SIZE_LOG2, data: '0, fixed: fixed,
			texel_due: texel};
		return t;
	endfunction

	function automatic stim_row_t cfg_row(input reg_idx_t idx, input int data);
		stim_row_t t;
		t = '{kind: ROW_CFG, req: rd_req(0, 0, 0, 0), idx: idx, data: data, fixed: 1'b0,
			texel_due: '0};
		return t;
	endfunction

	function automatic tex_req_t random_req();
		tex_req_t r;
		int lim;
		r = '{default: '0};
		if ($urandom_range(0, 9) < 3) begin
			r.command = CMD_WRITE;
			r.level   = $urandom_range(0, 7);
			lim       = 1 << (TOP_LVL - r.level);
			r.row     = $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) : $urandom_range(0, lim - 1);
			r.col     = $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) : $urandom_range(0, lim - 1);
			r.texel   = $urandom;
		end else begin
			r.command = CMD_SAMPLE;
			for (int i = 0; i < 2; i++) begin
				logic [COORD_W-1:0] c;
				logic signed [DERIV_W-1:0] d;
				case ($urandom_range(0, 9))
					0: c = 0;
					1: c = COORD_ONE;
					2: c = $urandom_range(65537, 131071);
					default: c = $urandom_range(0, 65536);
				endcase
				case ($urandom_range(0, 7))
					0: d = $urandom;
					1: d = 0;
					default: begin
						d = $urandom_range(0, 1 << $urandom_range(8, 20));
						if ($urandom_range(0, 4) == 0) d = -d;
					end
				endcase
				if (i == 0) begin
					r.u  = c;
					r.du = d;
				end else begin
					r.v  = c;
					r.dv = d;
				end
			end
		end
		return r;
	endfunction

	// result side: random stalls in bursts
	initial begin
		result.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 10);
			result.ready = (stall_left == 0);
			if (stall_left > 0) stall_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			if (texels_due.size() == 0) begin
				$display("%0t: unexpected result %h%h%h%h", $time,
					result.red, result.green, result.blue, result.alpha);
				errors++;
			end else begin
				logic [31:0] want;
				want = texels_due.pop_front();
				n_checked++;
				if (result.red != want[31:24]) begin
					$display("%0t: red expected %h actual %h", $time, want[31:24], result.red);
					errors++;
				end
				if (result.green != want[23:16]) begin
					$display("%0t: green expected %h actual %h", $time, want[23:16], result.green);
					errors++;
				end
				if (result.blue != want[15:8]) begin
					$display("%0t: blue expected %h actual %h", $time, want[15:8], result.blue);
					errors++;
				end
				if (result.alpha != want[7:0]) begin
					$display("%0t: alpha expected %h actual %h", $time, want[7:0], result.alpha);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item.valid && item.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_MAX) begin
			$display("%0t: timeout, %0d results outstanding", $time, texels_due.size());
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		stim_row_t rows[$];
		logic [SIZE_W-1:0] phase_size[8] = '{3'd4, 3'd0, 3'd4, 3'd3, 3'd1, 3'd4, 3'd2, 3'd4};
		logic [MODE_W-1:0] phase_mode[8] = '{2'd1, 2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd2};
		errors = 0;
		n_samples = 0;
		n_writes = 0;
		n_checked = 0;
		quiet_cycles = 0;
		calm = 1'b1;
		cur_size = SIZE_RESET;
		cur_mode = MODE_RESET;
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.command = CMD_WRITE;
		item.write_level = '0;
		item.write_row = '0;
		item.write_column = '0;
		item.write_texel = '0;
		item.tex_u = '0;
		item.tex_v = '0;
		item.du_dx = '0;
		item.dv_dx = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_SIZE_LOG2;
		cfg.data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// samples run at sizes up to FILL_LOG2, so only that part of each level is filled
		for (int lvl = 0; lvl <= FILL_LOG2; lvl++)
			for (int r = 0; r < (1 << (FILL_LOG2 - lvl)); r++)
				for (int c = 0; c < (1 << (FILL_LOG2 - lvl)); c++)
					send_req(wr_req(lvl, r, c, $urandom), 1'b0, '0);
		calm = 1'b0;

		rows.push_back(cfg_row(REG_SIZE_LOG2, FILL_LOG2));
		rows.push_back(req_row(wr_req(0, 0, 0, 32'hFF008001), 0, '0));
		rows.push_back(req_row(wr_req(0, 15, 15, 32'h00FF7F80), 0, '0));
		rows.push_back(req_row(wr_req(0, 15, 0, 32'h12345678), 0, '0));
		rows.push_back(req_row(rd_req(0, 0, 0, 0), 1, 32'hFF008001));
		rows.push_back(req_row(rd_req(17'h1FFFF, 17'h1FFFF, 0, 0), 1, 32'h00FF7F80));
		rows.push_back(req_row(rd_req(0, 65536, 0, 0), 1, 32'h12345678));
		rows.push_back(req_row(rd_req(17'h08000, 17'h04321, 0, 0), 0, '0));
		rows.push_back(req_row(wr_req(7, 1, 0, 32'hDEADBEEF), 0, '0));
		rows.push_back(req_row(wr_req(3, 127, 127, 32'hCAFEF00D), 0, '0));
		rows.push_back(cfg_row(REG_FILTER_MODE, MODE_NEAREST));
		rows.push_back(req_row(rd_req(17'h07FFF, 17'h08000, 0, 0), 0, '0));
		rows.push_back(req_row(rd_req(65536, 65536, 0, 0), 1, 32'h00FF7F80));
		rows.push_back(cfg_row(REG_FILTER_MODE, 2));
		rows.push_back(req_row(rd_req(17'h0C000, 17'h03000, 0, 0), 0, '0));
		rows.push_back(req_row(rd_req(17'h0C000, 17'h03000, -1048576, 1048575), 0, '0));
		rows.push_back(req_row(rd_req(17'h0C000, 17'h03000, 512, 0), 0, '0));
		rows.push_back(req_row(rd_req(17'h0C000, 17'h03000, 0, 513), 0, '0));
		rows.push_back(req_row(rd_req(17'h05555, 17'h0AAAA, 17'h10000, 300), 0, '0));
		rows.push_back(cfg_row(REG_SIZE_LOG2, 0));
		rows.push_back(req_row(rd_req(17'h0C000, 17'h03000, 1000, 1000), 0, '0));
		rows.push_back(cfg_row(REG_FILTER_MODE, 3));
		rows.push_back(req_row(rd_req(17'h0C000, 17'h03000, 2000, 40000), 0, '0));
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) write_reg(rows[i].idx, rows[i].data);
			else send_req(rows[i].req, rows[i].fixed, rows[i].texel_due);
		end

		for (int p = 0; p < 8; p++) begin
			write_reg(REG_SIZE_LOG2, phase_size[p]);
			write_reg(REG_FILTER_MODE, phase_mode[p]);
			calm = (p == 7);
			for (int i = 0; i < PHASE_REQS; i++)
				send_req(random_req(), 1'b0, '0);
		end

		while (texels_due.size() != 0) @(negedge clk);
		repeat (IDLE_GAP) @(negedge clk);
		$display("Covered %0d samples and %0d writes over 8 size/filter settings,", n_samples,
			n_writes);
		$display("%0d filtered texels checked against the shadow predictor.", n_checked);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/mtf_pkg.sv
rtl/core/mtf_if.sv
rtl/core/mtf_front.sv
rtl/core/mtf_queue.sv
rtl/core/mtf_back.sv
rtl/core/mipmap_texture_filter.sv
rtl/core/mtf_checker.sv
tb/tb_mipmap_texture_filter.sv
